// ----- hw/rtl/arlh_pkg.sv -----
// Package for the AES round lane hash core: item types, command and status
// structs, controller states, S-box and secret tables, AES round function.
// No dependencies.
`default_nettype none
package arlh_pkg;

    localparam int LANE_COUNT = 16;
    localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;

    typedef logic [127:0] lane_t;

    typedef struct packed {
        logic [63:0] data_word;
        logic [3:0]  byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } out_item_t;

    typedef enum logic [2:0] {
        CFG_SEED_ENABLE = 3'd0,
        CFG_SEED_WORD_0 = 3'd1,
        CFG_SEED_WORD_1 = 3'd2,
        CFG_SEED_WORD_2 = 3'd3,
        CFG_SEED_WORD_3 = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_SEED,
        OP_UPDATE,
        OP_BLOCK,
        OP_BUTTERFLY,
        OP_TREE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [5:0] step;
    } cmd_t;

    typedef struct packed {
        logic open;
        logic last;
        logic full;
        logic nonempty;
        logic out_busy;
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_UPDATE,
        ST_BLOCK,
        ST_BLOCK_BFY,
        ST_FIN_BFY,
        ST_TREE
    } state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SECRET [256] = '{
        8'h24,8'h3F,8'h6A,8'h88,8'h85,8'hA3,8'h08,8'hD3,8'h13,8'h19,8'h8A,8'h2E,8'h03,8'h70,8'h73,8'h44,
        8'hA4,8'h09,8'h38,8'h22,8'h29,8'h9F,8'h31,8'hD0,8'h08,8'h2E,8'hFA,8'h98,8'hEC,8'h4E,8'h6C,8'h89,
        8'h45,8'h28,8'h21,8'hE6,8'h38,8'hD0,8'h13,8'h77,8'hBE,8'h54,8'h66,8'hCF,8'h34,8'hE9,8'h0C,8'h6C,
        8'hC0,8'hAC,8'h29,8'hB7,8'hC9,8'h7C,8'h50,8'hDD,8'h3F,8'h84,8'hD5,8'hB5,8'hB5,8'h47,8'h09,8'h17,
        8'h92,8'h16,8'hD5,8'hD9,8'h89,8'h79,8'hFB,8'h1B,8'hD1,8'h31,8'h0B,8'hA6,8'h98,8'hDF,8'hB5,8'hAC,
        8'h2F,8'hFD,8'h72,8'hDB,8'hD0,8'h1A,8'hDF,8'hB7,8'hB8,8'hE1,8'hAF,8'hED,8'h6A,8'h26,8'h7E,8'h96,
        8'hBA,8'h7C,8'h90,8'h45,8'hF1,8'h2C,8'h7F,8'h99,8'h24,8'hA1,8'h99,8'h47,8'hB3,8'h91,8'h6C,8'hF7,
        8'h08,8'h01,8'hF2,8'hE2,8'h85,8'h8E,8'hFC,8'h16,8'h63,8'h69,8'h20,8'hD8,8'h71,8'h57,8'h4E,8'h69,
        8'hA4,8'h58,8'hFE,8'hA3,8'hF4,8'h93,8'h3D,8'h7E,8'h0D,8'h95,8'h74,8'h8F,8'h72,8'h8E,8'hB6,8'h58,
        8'h71,8'h8B,8'hCD,8'h58,8'h82,8'h15,8'h4A,8'hEE,8'h7B,8'h54,8'hA4,8'h1D,8'hC2,8'h5A,8'h59,8'hB5,
        8'h9C,8'h30,8'hD5,8'h39,8'h2A,8'hF2,8'h60,8'h13,8'hC5,8'hD1,8'hB0,8'h23,8'h28,8'h60,8'h85,8'hF0,
        8'hCA,8'h41,8'h79,8'h18,8'hB8,8'hDB,8'h38,8'hEF,8'h8E,8'h79,8'hDC,8'hB0,8'h60,8'h3A,8'h18,8'h0E,
        8'h6C,8'h9E,8'h0E,8'h8B,8'hB0,8'h1E,8'h8A,8'h3E,8'hD7,8'h15,8'h77,8'hC1,8'hBD,8'h31,8'h4B,8'h27,
        8'h78,8'hAF,8'h2F,8'hDA,8'h55,8'h60,8'h5C,8'h60,8'hE6,8'h55,8'h25,8'hF3,8'hAA,8'h55,8'hAB,8'h94,
        8'h57,8'h48,8'h98,8'h62,8'h63,8'hE8,8'h14,8'h40,8'h55,8'hCA,8'h39,8'h6A,8'h2A,8'hAB,8'h10,8'hB6,
        8'hB4,8'hCC,8'h5C,8'h34,8'h11,8'h41,8'hE8,8'hCE,8'hA1,8'h54,8'h86,8'hAF,8'h7C,8'h72,8'hE9,8'h93
    };

    function automatic lane_t secret_lane(input logic [3:0] idx);
        lane_t r;
        for (int b = 0; b < 16; b++) begin
            r[8*b +: 8] = SECRET[{idx, 4'(b)}];
        end
        return r;
    endfunction

    function automatic logic [63:0] secret_word(input logic [4:0] idx);
        logic [63:0] r;
        for (int b = 0; b < 8; b++) begin
            r[8*b +: 8] = SECRET[{idx, 3'(b)}];
        end
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic lane_t aes_round(input lane_t s, input lane_t k);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        lane_t o;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = SBOX[s[8*(r + 4*((c + r) & 3)) +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c];
            a1 = t[4*c+1];
            a2 = t[4*c+2];
            a3 = t[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            o[8*(4*c)   +: 8] = a0 ^ all ^ xtime(a0 ^ a1) ^ k[8*(4*c)   +: 8];
            o[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2) ^ k[8*(4*c+1) +: 8];
            o[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3) ^ k[8*(4*c+2) +: 8];
            o[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0) ^ k[8*(4*c+3) +: 8];
        end
        return o;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/aes_round_lane_hash_core.sv -----
// Top level of the AES round lane hash core: controller plus datapath.
// Depends on arlh_pkg, arlh_ctrl, arlh_datapath.
//
//   channel | ports                       | payload
//   input   | s_valid, s_ready, s_item    | data_word, byte_count, last_word
//   result  | m_valid, m_ready, m_item    | digest_high, digest_low
//   config  | cfg_wr_en, cfg_index, cfg_wdata | seed_enable, seed_word_0..3
//
// Each item is accepted, then the counters are updated; the first item of a
// message adds lane setup, through the shared AES round unit when seeding is
// enabled. A full 32-word block adds block rounds and a butterfly pass; the
// finish adds an optional padded block, a butterfly pass and a tree pass.
// Reset is synchronous; no clearing pass. A waiting digest stalls only the
// last tree step of the next message.
`default_nettype none
module aes_round_lane_hash_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire arlh_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output arlh_pkg::out_item_t      m_item
);

    arlh_pkg::cmd_t    cmd;
    arlh_pkg::status_t status;

    arlh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    arlh_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_item   (s_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (m_item)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/arlh_ctrl.sv -----
// Controller state machine of the AES round lane hash core.
// Sequences seeding, block rounds, butterflies and the finish tree.
// Depends on arlh_pkg.
`default_nettype none
module arlh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire arlh_pkg::status_t status,
    output arlh_pkg::cmd_t         cmd
);

    arlh_pkg::state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= arlh_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd.op     = arlh_pkg::OP_NONE;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            arlh_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cnt_next = '0;
                if (s_valid) begin
                    cmd.op     = arlh_pkg::OP_CAPTURE;
                    state_next = status.open ? arlh_pkg::ST_UPDATE : arlh_pkg::ST_SEED;
                end
            end
            arlh_pkg::ST_SEED: begin
                cmd.op   = arlh_pkg::OP_SEED;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15) begin
                    cnt_next   = '0;
                    state_next = arlh_pkg::ST_UPDATE;
                end
            end
            arlh_pkg::ST_UPDATE: begin
                cmd.op   = arlh_pkg::OP_UPDATE;
                cnt_next = '0;
                if (!status.last) begin
                    state_next = status.full ? arlh_pkg::ST_BLOCK : arlh_pkg::ST_IDLE;
                end else begin
                    state_next = status.nonempty ? arlh_pkg::ST_BLOCK : arlh_pkg::ST_FIN_BFY;
                end
            end
            arlh_pkg::ST_BLOCK: begin
                cmd.op   = arlh_pkg::OP_BLOCK;
                cnt_next = (cnt_reg[1:0] == 2'd2) ? cnt_reg + 6'd2 : cnt_reg + 6'd1;
                if (cnt_reg == 6'd62) begin
                    cnt_next   = '0;
                    state_next = arlh_pkg::ST_BLOCK_BFY;
                end
            end
            arlh_pkg::ST_BLOCK_BFY: begin
                cmd.op   = arlh_pkg::OP_BUTTERFLY;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15) begin
                    cnt_next   = '0;
                    state_next = status.last ? arlh_pkg::ST_FIN_BFY : arlh_pkg::ST_IDLE;
                end
            end
            arlh_pkg::ST_FIN_BFY: begin
                cmd.op   = arlh_pkg::OP_BUTTERFLY;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd15) begin
                    cnt_next   = '0;
                    state_next = arlh_pkg::ST_TREE;
                end
            end
            arlh_pkg::ST_TREE: begin
                if (cnt_reg != 6'd15) begin
                    cmd.op   = arlh_pkg::OP_TREE;
                    cnt_next = cnt_reg + 6'd1;
                end else if (!status.out_busy) begin
                    cmd.op     = arlh_pkg::OP_TREE;
                    cnt_next   = '0;
                    state_next = arlh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = arlh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/arlh_datapath.sv -----
// Datapath of the AES round lane hash core: lanes, block memory, counters,
// seed registers, one shared AES round unit and the digest register.
// Depends on arlh_pkg.
`default_nettype none
module arlh_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_wdata,
    input  wire arlh_pkg::in_item_t  in_item,
    input  wire arlh_pkg::cmd_t      cmd,
    output arlh_pkg::status_t        status,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output arlh_pkg::out_item_t      out_item
);

    arlh_pkg::lane_t lane_reg [arlh_pkg::LANE_COUNT];
    arlh_pkg::lane_t acc_reg  [8];
    arlh_pkg::lane_t tmp_reg;
    logic [63:0] mem [32];
    logic [63:0] rdata_reg;
    logic [63:0] kw_lo_reg;
    logic [63:0] k_reg;
    logic [63:0] total_reg;
    logic [4:0]  w_reg;
    logic [3:0]  count_reg;
    logic        last_reg;
    logic        open_reg;
    logic        out_valid_reg;
    arlh_pkg::out_item_t out_reg;

    logic        seed_en_reg;
    logic [63:0] seed0_reg, seed1_reg, seed2_reg, seed3_reg;

    logic [3:0] blk_lane;
    logic [1:0] blk_phase;
    logic [4:0] rd_addr;
    logic [2:0] pair;
    logic [3:0] tstep;
    arlh_pkg::lane_t aes_x, aes_y, aes_o, slice, blk_key;
    logic [2:0] tdst;

    function automatic logic [63:0] key_word(input logic [63:0] d, input logic [4:0] idx,
                                             input logic lst, input logic [4:0] w,
                                             input logic [3:0] cnt);
        logic [63:0] sw;
        logic [63:0] r;
        sw = arlh_pkg::secret_word(idx);
        r  = d;
        if (lst && idx > w) begin
            r = sw;
        end else if (lst && idx == w) begin
            for (int b = 0; b < 8; b++) begin
                r[8*b +: 8] = (4'(b) < cnt) ? d[8*b +: 8] : sw[8*b +: 8];
            end
        end
        return r;
    endfunction

    assign blk_lane  = cmd.step[5:2];
    assign blk_phase = cmd.step[1:0];
    assign rd_addr   = {blk_lane, blk_phase[0]};
    assign pair      = cmd.step[3:1];
    assign tstep     = cmd.step[3:0];

    always_comb begin
        slice = {key_word(rdata_reg, {blk_lane, 1'b1}, last_reg, w_reg, count_reg), kw_lo_reg};
        for (int j = 0; j < 16; j++) begin
            blk_key[8*j +: 8] = slice[8*(4'(j) ^ blk_lane) +: 8];
        end
    end

    always_comb begin
        aes_x = lane_reg[blk_lane];
        aes_y = blk_key;
        tdst  = tstep[2:0];
        unique case (cmd.op)
            arlh_pkg::OP_SEED: begin
                aes_x = arlh_pkg::secret_lane(tstep) ^ {seed1_reg, seed0_reg} ^ {k_reg, ~k_reg};
                aes_y = {seed3_reg, seed2_reg};
            end
            arlh_pkg::OP_BUTTERFLY: begin
                if (!cmd.step[0]) begin
                    aes_x = lane_reg[{1'b0, pair}];
                    aes_y = lane_reg[{1'b1, pair}];
                end else begin
                    aes_x = lane_reg[{1'b1, pair}];
                    aes_y = lane_reg[{1'b0, pair}];
                end
            end
            arlh_pkg::OP_TREE: begin
                priority if (!tstep[3]) begin
                    aes_x = lane_reg[{1'b0, tstep[2:0]}];
                    aes_y = lane_reg[{1'b1, tstep[2:0]}];
                end else if (!tstep[2]) begin
                    aes_x = acc_reg[{1'b0, tstep[1:0]}];
                    aes_y = acc_reg[{1'b1, tstep[1:0]}];
                    tdst  = {1'b0, tstep[1:0]};
                end else if (!tstep[1]) begin
                    aes_x = acc_reg[{2'b00, tstep[0]}];
                    aes_y = acc_reg[{2'b01, tstep[0]}];
                    tdst  = {2'b00, tstep[0]};
                end else if (!tstep[0]) begin
                    aes_x = acc_reg[0];
                    aes_y = acc_reg[1];
                    tdst  = 3'd0;
                end else begin
                    aes_x = acc_reg[0];
                    aes_y = {total_reg, ~total_reg};
                    tdst  = 3'd0;
                end
            end
            default: begin
            end
        endcase
        aes_o = arlh_pkg::aes_round(aes_x, aes_y);
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == arlh_pkg::OP_CAPTURE) begin
            mem[w_reg] <= in_item.data_word;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_en_reg <= 1'b0;
            seed0_reg   <= '0;
            seed1_reg   <= '0;
            seed2_reg   <= '0;
            seed3_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                arlh_pkg::CFG_SEED_ENABLE: seed_en_reg <= cfg_wdata[0];
                arlh_pkg::CFG_SEED_WORD_0: seed0_reg   <= cfg_wdata;
                arlh_pkg::CFG_SEED_WORD_1: seed1_reg   <= cfg_wdata;
                arlh_pkg::CFG_SEED_WORD_2: seed2_reg   <= cfg_wdata;
                arlh_pkg::CFG_SEED_WORD_3: seed3_reg   <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg         <= '0;
            total_reg     <= '0;
            open_reg      <= 1'b0;
            last_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                arlh_pkg::OP_CAPTURE: begin
                    word_capture: begin
                        last_reg  <= in_item.last_word;
                        count_reg <= (in_item.byte_count > 4'd8) ? 4'd8 : in_item.byte_count;
                        open_reg  <= 1'b1;
                    end
                end
                arlh_pkg::OP_UPDATE: begin
                    if (!last_reg) begin
                        total_reg <= total_reg + 64'd8;
                        w_reg     <= (w_reg == 5'd31) ? 5'd0 : w_reg + 5'd1;
                    end else begin
                        total_reg <= total_reg + {60'd0, count_reg};
                    end
                end
                arlh_pkg::OP_TREE: begin
                    if (tstep == 4'd15) begin
                        out_valid_reg <= 1'b1;
                        w_reg         <= '0;
                        total_reg     <= '0;
                        open_reg      <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            arlh_pkg::OP_CAPTURE: begin
                k_reg <= '0;
            end
            arlh_pkg::OP_SEED: begin
                k_reg <= k_reg + arlh_pkg::GOLDEN_STEP;
                lane_reg[tstep] <= seed_en_reg ? aes_o : arlh_pkg::secret_lane(tstep);
            end
            arlh_pkg::OP_BLOCK: begin
                if (blk_phase == 2'd1) begin
                    kw_lo_reg <= key_word(rdata_reg, {blk_lane, 1'b0}, last_reg, w_reg,
                                          count_reg);
                end
                if (blk_phase == 2'd2) begin
                    lane_reg[blk_lane] <= aes_o;
                end
            end
            arlh_pkg::OP_BUTTERFLY: begin
                if (!cmd.step[0]) begin
                    tmp_reg <= aes_o;
                end else begin
                    lane_reg[{1'b0, pair}] <= tmp_reg;
                    lane_reg[{1'b1, pair}] <= aes_o;
                end
            end
            arlh_pkg::OP_TREE: begin
                if (tstep == 4'd15) begin
                    out_reg.digest_low  <= aes_o[63:0];
                    out_reg.digest_high <= aes_o[127:64];
                end else begin
                    acc_reg[tdst] <= aes_o;
                end
            end
            default: begin
            end
        endcase
    end

    assign status.open     = open_reg;
    assign status.last     = last_reg;
    assign status.full     = (w_reg == 5'd31);
    assign status.nonempty = (w_reg != 5'd0) || (count_reg != 4'd0);
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/arlh_checker.sv -----
// Port-level checker for the AES round lane hash core, bound to the top level.
// Depends on arlh_pkg and aes_round_lane_hash_core.
`default_nettype none
module arlh_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire arlh_pkg::out_item_t m_item
);

    a_reset_no_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result dropped or changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while previous item still in work");

    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while block was idle");

endmodule

bind aes_round_lane_hash_core arlh_checker u_arlh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
`default_nettype wire

// ----- sim/aes_round_lane_hash_core_tb.sv -----
// Self-checking testbench for aes_round_lane_hash_core: drives 64-bit message
// words with random gaps and result stalls, predicts digests in a scoreboard.
// Depends on arlh_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none

class digest_scoreboard;
    typedef logic [127:0] blk_t;
    localparam logic [63:0] PHI = 64'h9E3779B97F4A7C15;

    logic [7:0] sb [256];
    logic [7:0] key_bytes [256];
    blk_t lanes [16];
    logic [63:0] words [32];
    int unsigned fill;
    logic [63:0] total;
    bit open;
    bit seed_on;
    logic [63:0] seed [4];
    arlh_pkg::out_item_t pending [$];
    int errors;

    function new();
        foreach (sb[i]) sb[i] = arlh_pkg::SBOX[i];
        foreach (key_bytes[i]) key_bytes[i] = arlh_pkg::SECRET[i];
        seed_on = 0;
        foreach (seed[i]) seed[i] = '0;
        open = 0;
        fill = 0;
        total = '0;
        errors = 0;
    endfunction

    function void set_reg(arlh_pkg::cfg_index_t idx, logic [63:0] v);
        case (idx)
            arlh_pkg::CFG_SEED_ENABLE: seed_on = v[0];
            arlh_pkg::CFG_SEED_WORD_0: seed[0] = v;
            arlh_pkg::CFG_SEED_WORD_1: seed[1] = v;
            arlh_pkg::CFG_SEED_WORD_2: seed[2] = v;
            arlh_pkg::CFG_SEED_WORD_3: seed[3] = v;
            default: ;
        endcase
    endfunction

    function logic [7:0] xt(logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function blk_t enc_round(blk_t s, blk_t k);
        logic [7:0] t [16];
        logic [7:0] a [4];
        logic [7:0] mx;
        blk_t o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r + 4*c] = sb[s[8*(r + 4*((c + r) % 4)) +: 8]];
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) a[r] = t[4*c + r];
            mx = a[0] ^ a[1] ^ a[2] ^ a[3];
            for (int r = 0; r < 4; r++)
                o[8*(4*c + r) +: 8] = a[r] ^ mx ^ xt(a[r] ^ a[(r + 1) % 4])
                                      ^ k[8*(4*c + r) +: 8];
        end
        return o;
    endfunction

    function void mix_lanes();
        blk_t n [16];
        for (int i = 0; i < 8; i++) begin
            n[i] = enc_round(lanes[i], lanes[i + 8]);
            n[i + 8] = enc_round(lanes[i + 8], lanes[i]);
        end
        lanes = n;
    endfunction

    function void absorb(logic [7:0] blk [256]);
        blk_t k;
        for (int i = 0; i < 16; i++) begin
            for (int j = 0; j < 16; j++) k[8*j +: 8] = blk[16*i + (j ^ i)];
            lanes[i] = enc_round(lanes[i], k);
        end
        mix_lanes();
    endfunction

    function void begin_message();
        blk_t s0, s1, d;
        logic [63:0] m;
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++) lanes[i][8*j +: 8] = key_bytes[16*i + j];
        if (seed_on) begin
            s0 = {seed[1], seed[0]};
            s1 = {seed[3], seed[2]};
            for (int i = 0; i < 16; i++) begin
                m = 64'(i) * PHI;
                d = {m, ~m};
                lanes[i] = enc_round(lanes[i] ^ s0 ^ d, s1);
            end
        end
        fill = 0;
        total = '0;
        open = 1;
    endfunction

    function void note_item(arlh_pkg::in_item_t it);
        logic [7:0] blk [256];
        int unsigned cnt;
        blk_t a [8];
        blk_t d;
        if (!open) begin_message();
        words[fill] = it.data_word;
        if (!it.last_word) begin
            total += 64'd8;
            fill++;
            if (fill == 32) begin
                for (int n = 0; n < 256; n++) blk[n] = words[n / 8][8*(n % 8) +: 8];
                absorb(blk);
                fill = 0;
            end
            return;
        end
        cnt = (it.byte_count > 8) ? 8 : it.byte_count;
        total += 64'(cnt);
        if (8*fill + cnt > 0) begin
            blk = key_bytes;
            for (int n = 0; n < 8*fill + cnt; n++) blk[n] = words[n / 8][8*(n % 8) +: 8];
            absorb(blk);
        end
        mix_lanes();
        for (int i = 0; i < 8; i++) a[i] = enc_round(lanes[i], lanes[i + 8]);
        for (int i = 0; i < 4; i++) a[i] = enc_round(a[i], a[i + 4]);
        for (int i = 0; i < 2; i++) a[i] = enc_round(a[i], a[i + 2]);
        d = enc_round(enc_round(a[0], a[1]), {total, ~total});
        pending.push_back('{digest_high: d[127:64], digest_low: d[63:0]});
        fill = 0;
        open = 0;
    endfunction

    function void check_result(arlh_pkg::out_item_t got);
        arlh_pkg::out_item_t want;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected digest %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.digest_low !== want.digest_low || got.digest_high !== want.digest_high) begin
            errors++;
            if (errors <= 10)
                $display("digest mismatch: expected %h_%h got %h_%h",
                         want.digest_high, want.digest_low, got.digest_high, got.digest_low);
        end
    endfunction
endclass

module aes_round_lane_hash_core_tb;

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wr_en = 0;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    arlh_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 0;
    arlh_pkg::out_item_t m_item;

    digest_scoreboard board = new();
    bit stall_on = 0;
    int unsigned burst_left = 0;

    aes_round_lane_hash_core dut (.*);

    initial forever #1 aclk = ~aclk;

    initial begin
        #4000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_item);
        if (stall_on) m_ready <= ($urandom_range(0, 3) != 0) ^ ($urandom_range(0, 15) == 0);
        else m_ready <= 1'b1;
    end

    task automatic write_reg(arlh_pkg::cfg_index_t idx, logic [63:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        board.set_reg(idx, v);
    endtask

    task automatic send_word(logic [63:0] w, logic [3:0] cnt, logic fin);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item <= '{data_word: w, byte_count: cnt, last_word: fin};
        do @(posedge aclk); while (!s_ready);
        board.note_item('{data_word: w, byte_count: cnt, last_word: fin});
    endtask

    task automatic send_message(int unsigned nwords, logic [3:0] cnt);
        for (int unsigned i = 0; i < nwords; i++)
            send_word({$urandom, $urandom}, 4'($urandom), 1'b0);
        send_word({$urandom, $urandom}, cnt, 1'b1);
    endtask

    task automatic drain();
        int unsigned guard = 0;
        s_valid <= 1'b0;
        while (board.pending.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (300) @(posedge aclk);
    endtask

    task automatic program_seed(logic en, logic [63:0] a, logic [63:0] b,
                                logic [63:0] c, logic [63:0] d);
        write_reg(arlh_pkg::CFG_SEED_ENABLE, {63'($urandom), en});
        write_reg(arlh_pkg::CFG_SEED_WORD_0, a);
        write_reg(arlh_pkg::CFG_SEED_WORD_1, b);
        write_reg(arlh_pkg::CFG_SEED_WORD_2, c);
        write_reg(arlh_pkg::CFG_SEED_WORD_3, d);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned sent;
        int unsigned len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(64'h0, 4'd0, 1'b1);
        send_word('1, 4'd8, 1'b1);
        send_word(64'h0123456789abcdef, 4'd15, 1'b1);
        send_word(64'hfedcba9876543210, 4'd3, 1'b1);
        send_message(1, 4'd0);
        send_message(31, 4'd0);
        send_message(31, 4'd8);
        send_message(32, 4'd0);
        send_message(32, 4'd9);
        drain();
        program_seed(1'b1, '1, '1, '1, '1);
        send_word('1, 4'd8, 1'b1);
        send_message(3, 4'd5);
        drain();
        program_seed(1'b1, '0, '0, '0, '0);
        send_word(64'h0, 4'd1, 1'b1);
        drain();

        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase > 0)
                program_seed(phase[0], {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom});
            stall_on = (phase != 1);
            while (sent < 300 * (phase + 1)) begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(32, 70);
                    1: len = 31;
                    default: len = $urandom_range(0, 12);
                endcase
                send_message(len, 4'($urandom_range(0, 15)));
                sent += len + 1;
            end
            drain();
        end
        stall_on = 0;
        drain();
        if (board.errors == 0 && board.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
